### rtl/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types and codes for the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned GestW  = 2;
  localparam int unsigned TallyW = 2;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW   = 2'd2;

  // register reset values
  localparam logic [CfgW-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CfgW-1:0] LONG_RST     = 16'd1000;
  localparam logic [CfgW-1:0] WINDOW_RST   = 16'd300;

  // gesture codes
  localparam logic [GestW-1:0] G_NONE   = 2'd0;
  localparam logic [GestW-1:0] G_SINGLE = 2'd1;
  localparam logic [GestW-1:0] G_DOUBLE = 2'd2;
  localparam logic [GestW-1:0] G_LONG   = 2'd3;

  localparam logic [TallyW-1:0] TALLY_MAX = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2,
    PH_RELEASED = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_time;
    logic [CfgW-1:0] long_press_time;
    logic [CfgW-1:0] double_click_window;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             pin_level;
    logic             edge_event;
  } poll_t;

endpackage

### rtl/bgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bgc_cfg_regs
// Configuration register file: three 16-bit timing registers.
// ----------------------------------------------------------------------------
module bgc_cfg_regs
  import bgc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_wdata,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE: cfg_nxt.debounce_time       = cfg_wdata;
        CFG_LONG:     cfg_nxt.long_press_time     = cfg_wdata;
        CFG_WINDOW:   cfg_nxt.double_click_window = cfg_wdata;
        default:      cfg_nxt = cfg_r;  // unused index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time       <= DEBOUNCE_RST;
      cfg_r.long_press_time     <= LONG_RST;
      cfg_r.double_click_window <= WINDOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/bgc_in_stage.sv
// ----------------------------------------------------------------------------
// bgc_in_stage
// Input register: holds one poll until the core steps on it.
// ----------------------------------------------------------------------------
module bgc_in_stage
  import bgc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [TimeW-1:0] in_now_ms,
  input  logic             in_pin_level,
  input  logic             in_edge_event,
  input  logic             advance,
  output logic             poll_valid,
  output poll_t            poll
);

  logic  valid_r;
  logic  valid_nxt;
  poll_t poll_r;
  logic  load;

  assign in_stall  = valid_r && !advance;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      poll_r.now_ms     <= in_now_ms;
      poll_r.pin_level  <= in_pin_level;
      poll_r.edge_event <= in_edge_event;
    end
  end

  assign poll_valid = valid_r;
  assign poll       = poll_r;

endmodule

### rtl/bgc_core.sv
// ----------------------------------------------------------------------------
// bgc_core
// Gesture state machine: debounce, press timing and click tally.
// ----------------------------------------------------------------------------
module bgc_core
  import bgc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  poll_t            poll,
  input  cfg_t             cfg,
  output logic [GestW-1:0] gesture
);

  phase_t            phase_r,        phase_nxt;
  logic              edge_r,         edge_nxt;
  logic [TimeW-1:0]  deb_begin_r,    deb_begin_nxt;
  logic [TimeW-1:0]  press_begin_r,  press_begin_nxt;
  logic [TallyW-1:0] tally_r,        tally_nxt;
  logic [TimeW-1:0]  rel_time_r,     rel_time_nxt;

  logic [TimeW-1:0]  deb_elapsed;
  logic [TimeW-1:0]  hold_time;
  logic [TimeW-1:0]  gap_time;
  logic              edge_seen;

  assign deb_elapsed = poll.now_ms - deb_begin_r;
  assign hold_time   = poll.now_ms - press_begin_r;

  always_comb begin
    phase_nxt       = phase_r;
    deb_begin_nxt   = deb_begin_r;
    press_begin_nxt = press_begin_r;
    tally_nxt       = tally_r;
    rel_time_nxt    = rel_time_r;
    gesture         = G_NONE;
    edge_seen       = edge_r | poll.edge_event;
    edge_nxt        = edge_seen;

    case (phase_r)
      PH_IDLE: begin
        if (edge_seen) begin
          edge_nxt      = 1'b0;
          deb_begin_nxt = poll.now_ms;
          phase_nxt     = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        if (deb_elapsed >= {{(TimeW-CfgW){1'b0}}, cfg.debounce_time}) begin
          if (!poll.pin_level) begin
            press_begin_nxt = poll.now_ms;
            phase_nxt       = PH_PRESSED;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_PRESSED: begin
        if (poll.pin_level) begin
          phase_nxt = PH_RELEASED;
        end
      end
      PH_RELEASED: begin
        if (hold_time >= {{(TimeW-CfgW){1'b0}}, cfg.long_press_time}) begin
          gesture   = G_LONG;
          tally_nxt = '0;
        end else begin
          if (tally_r != TALLY_MAX) begin
            tally_nxt = tally_r + 1'b1;
          end
          rel_time_nxt = poll.now_ms;
        end
        phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase

    // click report once the window after the last short release has run out
    gap_time = poll.now_ms - rel_time_nxt;
    if ((tally_nxt != '0) &&
        (gap_time > {{(TimeW-CfgW){1'b0}}, cfg.double_click_window})) begin
      gesture   = (tally_nxt == 2'd1) ? G_SINGLE : G_DOUBLE;
      tally_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      edge_r        <= 1'b0;
      deb_begin_r   <= '0;
      press_begin_r <= '0;
      tally_r       <= '0;
      rel_time_r    <= '0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      edge_r        <= edge_nxt;
      deb_begin_r   <= deb_begin_nxt;
      press_begin_r <= press_begin_nxt;
      tally_r       <= tally_nxt;
      rel_time_r    <= rel_time_nxt;
    end
  end

  // long press only comes out of the released phase
  a_long_from_released: assert property (@(posedge clk) disable iff (!rst_n)
    (step && gesture == G_LONG) |-> phase_r == PH_RELEASED)
    else $error("long press reported outside released phase");

  // a click report needs a pending click from an earlier release
  a_click_needs_tally: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (gesture == G_SINGLE || gesture == G_DOUBLE)) |-> tally_r != '0)
    else $error("click reported with empty tally");

  // any reported gesture leaves the tally empty
  a_report_clears_tally: assert property (@(posedge clk) disable iff (!rst_n)
    (step && gesture != G_NONE) |=> tally_r == '0)
    else $error("tally not cleared after report");

  // entering debounce consumes the latched edge
  a_edge_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == PH_IDLE && phase_nxt == PH_DEBOUNCE) |=> !edge_r)
    else $error("edge still latched after debounce start");

  // state only moves on a step
  a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(tally_r))
    else $error("state changed without a transaction");

endmodule

### rtl/button_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Debounces an active-low push button and classifies single, double and
// long presses from millisecond-stamped polls.
// ----------------------------------------------------------------------------
// Each input transaction is one poll (timestamp, pin level, edge flag) and
// yields exactly one output transaction carrying a gesture code: 0 none,
// 1 single click, 2 double click, 3 long press. The block takes one poll per
// clock while out_stall is low. The poll first lands in the input register,
// and the state update then writes the output register. Throughput is one
// transaction per cycle while out_stall is low, set by the state update,
// which is a few 32-bit subtracts and compares. in_stall rises only while the
// input register holds a poll and the output register is full and stalled.
// Time differences wrap modulo 2^32. The three timing registers (debounce
// time, long press threshold, double-click window, in ms, 16 bits each) are
// written through cfg_we/cfg_index/cfg_wdata; the user must see that they are
// written only while the block is idle, which the block does not enforce;
// index 3 is ignored.
// ----------------------------------------------------------------------------
module button_gesture_classifier
  import bgc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // poll input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [TimeW-1:0]   in_now_ms,
  input  logic               in_pin_level,
  input  logic               in_edge_event,
  // gesture output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [GestW-1:0]   out_gesture,
  // configuration write port
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_wdata
);

  cfg_t             cfg;
  poll_t            poll;
  logic             poll_valid;
  logic             advance;
  logic [GestW-1:0] gesture;

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [GestW-1:0] gesture_r;

  // the core steps when a poll is waiting and the output register has room
  // (empty, or its transaction completes this cycle)
  assign advance = poll_valid && (!out_valid_r || !out_stall);

  bgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bgc_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_now_ms     (in_now_ms),
    .in_pin_level  (in_pin_level),
    .in_edge_event (in_edge_event),
    .advance       (advance),
    .poll_valid    (poll_valid),
    .poll          (poll)
  );

  bgc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .poll    (poll),
    .cfg     (cfg),
    .gesture (gesture)
  );

  // output register
  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gesture_r <= gesture;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_gesture = gesture_r;

endmodule

### test/button_gesture_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_gesture_classifier_tb
// Self-checking bench: random polls against a cycle-free gesture predictor.
// ----------------------------------------------------------------------------
// A directed run covers bounce rejection, edges arriving outside idle, an
// exact long-press threshold, click-tally saturation across the 2^32 time
// wrap and the window boundary. Random phases then sweep several timing
// settings (all-zero, all-max, mixed, random) with mostly well-formed press
// sequences plus noise. Both handshakes see random idle, one long receiver
// hold-off fills the pipe, and the sender pauses mid-phase to let it drain.
// ----------------------------------------------------------------------------
module button_gesture_classifier_tb;
  import bgc_pkg::*;

  localparam int unsigned PIPE_LAT    = 2;       // poll -> gesture, cycles
  localparam int unsigned MAX_IDLE    = 10;      // per-transaction idle draw
  localparam int unsigned LONG_HOLD   = 300;     // receiver hold-off, cycles
  localparam int unsigned PHASE_POLLS = 163;     // random polls per setting
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // index 3 is not a register; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    poll_t       poll;
    int unsigned gap;     // idle cycles before this transaction is offered
  } pending_poll_t;

  // --------------------------------------------------------------------------
  // DUT and its inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [TimeW-1:0]   in_now_ms = '0;
  logic               in_pin_level = 1'b1;
  logic               in_edge_event = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [GestW-1:0]   out_gesture;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;

  button_gesture_classifier dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_now_ms     (in_now_ms),
    .in_pin_level  (in_pin_level),
    .in_edge_event (in_edge_event),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_gesture   (out_gesture),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  pending_poll_t    poll_q[$];          // polls waiting for the driver
  logic [GestW-1:0] gesture_q[$];       // predicted gestures, oldest first
  pending_poll_t    tx_item;
  int unsigned      idle_wait = 0;
  logic [TimeW-1:0] poll_clock = '0;    // running ms timestamp for stimulus
  int unsigned      polls_queued = 0;
  int unsigned      polls_taken = 0;
  int unsigned      errors = 0;
  int unsigned      cycles = 0;
  int unsigned      settings_run = 0;
  int unsigned      gesture_tally[4] = '{0, 0, 0, 0};
  logic [GestW-1:0] want_gesture;
  bit               tx_quiet = 1'b0;    // zero-gap stretch on the sender
  bit               force_quiet = 1'b0;
  bit               rx_quiet = 1'b0;    // zero-stall stretch on the receiver
  int unsigned      hold_req = 0;       // bumped to request a long hold-off
  int unsigned      hold_seen = 0;
  int unsigned      stall_left = 0;

  // predictor copy of the timing registers and machine state
  cfg_t             timing = '{DEBOUNCE_RST, LONG_RST, WINDOW_RST};
  phase_t           cur_phase = PH_IDLE;
  logic             pend_edge = 1'b0;
  logic [TimeW-1:0] deb_start = '0;
  logic [TimeW-1:0] press_start = '0;
  logic [TallyW-1:0] clicks = '0;
  logic [TimeW-1:0] last_release = '0;

  // --------------------------------------------------------------------------
  // Gesture predictor: one call per accepted poll, updates the shadow state
  // --------------------------------------------------------------------------
  function automatic logic [GestW-1:0] classify_poll(input logic [TimeW-1:0] now,
                                                     input logic lvl,
                                                     input logic edg);
    logic [GestW-1:0] g;
    logic [TimeW-1:0] elapsed;
    g = G_NONE;
    // edge sticks until the idle phase picks it up
    if (edg) pend_edge = 1'b1;
    case (cur_phase)
      PH_IDLE: begin
        if (pend_edge) begin
          pend_edge = 1'b0;
          deb_start = now;
          cur_phase = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        elapsed = now - deb_start;
        if (elapsed >= TimeW'(timing.debounce_time)) begin
          if (!lvl) begin
            press_start = now;
            cur_phase = PH_PRESSED;
          end else begin
            cur_phase = PH_IDLE;
          end
        end
      end
      PH_PRESSED: begin
        if (lvl) cur_phase = PH_RELEASED;
      end
      default: begin
        elapsed = now - press_start;
        if (elapsed >= TimeW'(timing.long_press_time)) begin
          g = G_LONG;
          clicks = '0;
        end else begin
          if (clicks != TALLY_MAX) clicks = clicks + 1'b1;
          last_release = now;
        end
        cur_phase = PH_IDLE;
      end
    endcase
    // pending clicks are reported once the window has strictly passed
    elapsed = now - last_release;
    if (clicks != '0 && elapsed > TimeW'(timing.double_click_window)) begin
      g = (clicks == 2'd1) ? G_SINGLE : G_DOUBLE;
      clicks = '0;
    end
    return g;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued polls, holds payload while stalled
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (poll_q.size() != 0 && idle_wait >= poll_q[0].gap) begin
        tx_item = poll_q.pop_front();
        in_now_ms     <= tx_item.poll.now_ms;
        in_pin_level  <= tx_item.poll.pin_level;
        in_edge_event <= tx_item.poll.edge_event;
        in_valid      <= 1'b1;
        idle_wait = 0;
      end else begin
        in_valid <= 1'b0;
        if (poll_q.size() != 0) idle_wait++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall per transaction, long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) rx_quiet = ~rx_quiet;
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        stall_left = LONG_HOLD;
      end else if (out_valid && !out_stall) begin
        stall_left = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every input transaction, check every output one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        gesture_q.push_back(classify_poll(in_now_ms, in_pin_level, in_edge_event));
        polls_taken++;
      end
      if (out_valid && !out_stall) begin
        if (gesture_q.size() == 0) begin
          $error("out_gesture: transaction with nothing expected, actual %0d",
                 out_gesture);
          errors++;
        end else begin
          want_gesture = gesture_q.pop_front();
          gesture_tally[want_gesture]++;
          if (out_gesture !== want_gesture) begin
            $error("out_gesture mismatch: expected %0d actual %0d",
                   want_gesture, out_gesture);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("button_gesture_classifier verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEBOUNCE: timing.debounce_time = val;
      CFG_LONG:     timing.long_press_time = val;
      CFG_WINDOW:   timing.double_click_window = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(input int unsigned deb, input int unsigned lp,
                            input int unsigned win);
    write_reg(CFG_DEBOUNCE, CfgW'(deb));
    write_reg(CFG_LONG, CfgW'(lp));
    write_reg(CFG_WINDOW, CfgW'(win));
    settings_run++;
  endtask

  // advance the stimulus clock by delta ms and queue one poll
  task automatic push_poll(input int unsigned delta, input logic lvl, input logic edg);
    pending_poll_t p;
    poll_clock = poll_clock + delta;
    p.poll.now_ms     = poll_clock;
    p.poll.pin_level  = lvl;
    p.poll.edge_event = edg;
    p.gap = (tx_quiet || force_quiet) ? 0 : $urandom_range(0, MAX_IDLE);
    poll_q.push_back(p);
    polls_queued++;
  endtask

  // edge, optional bounce, debounce pass, hold for ~hold ms, release, evaluate
  task automatic gen_press(input int unsigned hold);
    int unsigned deb, nb, k, step, i;
    deb = timing.debounce_time;
    push_poll($urandom_range(0, 20), 1'b0, 1'b1);
    nb = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    for (i = 0; i < nb; i++)
      push_poll($urandom_range(0, deb / (nb + 1)), 1'($urandom_range(0, 1)),
                $urandom_range(0, 7) == 0);
    push_poll(deb, 1'b0, 1'b0);
    k = $urandom_range(0, 3);
    step = hold / (k + 2);
    // occasional edge while pressed stays latched for later
    for (i = 0; i < k; i++) push_poll(step, 1'b0, $urandom_range(0, 9) == 0);
    push_poll(step, 1'b1, 1'b0);
    push_poll(hold - (k + 1) * step, 1'($urandom_range(0, 1)), 1'b0);
  endtask

  task automatic gen_sequence();
    int unsigned kind, n, i, d, lp, win, short_max;
    lp  = timing.long_press_time;
    win = timing.double_click_window;
    short_max = (lp == 0) ? 0 : lp - 1;
    if (short_max > win) short_max = win;
    tx_quiet = ($urandom_range(0, 5) == 0);
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      // click burst, up to five so the tally saturates, then window edge
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) begin
        gen_press($urandom_range(0, short_max));
        push_poll($urandom_range(0, win / 4), 1'b1, 1'b0);
      end
      push_poll(win + $urandom_range(0, 2), 1'b1, 1'b0);
      push_poll($urandom_range(1, 50), 1'b1, 1'b0);
    end else if (kind < 6) begin
      gen_press(($urandom_range(0, 3) == 0) ? lp : lp + $urandom_range(1, 3000));
      push_poll(win + $urandom_range(1, 50), 1'b1, 1'b0);
    end else if (kind < 8) begin
      gen_press($urandom_range(0, lp + 500));
    end else begin
      // noise: any timestamp step, level and edge
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(0, 2))
          0:       d = $urandom_range(0, 3);
          1:       d = $urandom_range(0, 65535);
          default: d = $urandom;
        endcase
        push_poll(d, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // wait until every poll is taken and every gesture has come back
  task automatic drain();
    while (polls_taken != polls_queued || gesture_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 3) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned ph, start, i;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // write to the unused index must leave the reset timing alone
    write_reg(CFG_UNUSED, 16'hFFFF);
    settings_run++;

    // bounce: level high at the end of debounce goes back to idle
    push_poll(10, 1'b1, 1'b1);
    push_poll(50, 1'b1, 1'b0);
    // edge during debounce stays latched through a press of exactly the
    // long threshold, then restarts debounce once back in idle
    push_poll(5, 1'b0, 1'b1);
    push_poll(5, 1'b0, 1'b1);
    push_poll(45, 1'b0, 1'b0);
    push_poll(LONG_RST, 1'b1, 1'b0);
    push_poll(0, 1'b0, 1'b0);
    push_poll(1, 1'b1, 1'b0);
    push_poll(50, 1'b1, 1'b0);
    // four short clicks across the timestamp wrap: tally saturates
    poll_clock = 32'hFFFF_FFFF - 100;
    for (i = 0; i < 4; i++) begin
      push_poll(1, 1'b0, 1'b1);
      push_poll(50, 1'b0, 1'b0);
      push_poll(20, 1'b1, 1'b0);
      push_poll(5, 1'b1, 1'b0);
    end
    // exactly the window is not enough; one more ms reports a double
    push_poll(WINDOW_RST, 1'b1, 1'b0);
    push_poll(1, 1'b1, 1'b0);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       set_timing(DEBOUNCE_RST, LONG_RST, WINDOW_RST);
        1:       set_timing(0, 0, 0);
        2:       set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        3:       set_timing(0, 16'hFFFF, 16'hFFFF);
        default: begin
          set_timing($urandom_range(0, 200), $urandom_range(1, 3000),
                     $urandom_range(0, 1000));
          write_reg(CFG_UNUSED, CfgW'($urandom));
        end
      endcase
      if (ph == 2 || ph == 6) poll_clock = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      start = polls_queued;
      // back-to-back offers against a long receiver hold-off
      if (ph == 5) begin
        force_quiet = 1'b1;
        hold_req++;
      end
      while (polls_queued - start < PHASE_POLLS / 2) gen_sequence();
      force_quiet = 1'b0;
      // sender pauses until everything has come back
      if (ph == 4) drain();
      while (polls_queued - start < PHASE_POLLS) gen_sequence();
      drain();
    end

    $display("Covered %0d polls under %0d timing settings in %0d cycles",
             polls_taken, settings_run, cycles);
    $display("Gestures seen: none %0d, single %0d, double %0d, long %0d",
             gesture_tally[G_NONE], gesture_tally[G_SINGLE],
             gesture_tally[G_DOUBLE], gesture_tally[G_LONG]);
    if (errors == 0) begin
      $display("button_gesture_classifier verification clean");
    end else begin
      $display("button_gesture_classifier verification failed");
    end
    $finish;
  end

endmodule
